// ===== hdl/lpcw_pkg.sv =====
package lpcw_pkg;

  // Width of the time base used for the elapsed time since the last cut.
  localparam int unsigned TimeWidth = 32;
  localparam logic [63:0] TimeMask  = {64{1'b1}} >> (64 - TimeWidth);

  // Reciprocal of 100 scaled by 2^37; exact for every 32-bit dividend.
  localparam logic [31:0] Recip100      = 32'h51EB_851F;
  localparam int unsigned Recip100Shift = 37;

  // Register reset values.
  localparam logic [15:0] SegmentSizeReset = 16'd536;
  localparam logic [6:0]  ThresholdReset   = 7'd15;

  typedef logic [3:0] step_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SEGMENT_SIZE = 2'd0,
    REG_THRESHOLD    = 2'd1
  } cfg_reg_e;

  // Kind of window change reported with each result.
  typedef enum logic [1:0] {
    CUT_NONE    = 2'd0,
    CUT_HALVED  = 2'd1,
    CUT_SEGMENT = 2'd2
  } cut_kind_e;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIFF,
    OP_SPAN,
    OP_BOUNDS,
    OP_SMOOTH,
    OP_INF_RANGE,
    OP_MUL_PCT,
    OP_MUL_RECIP,
    OP_LIMIT,
    OP_DECIDE
  } op_e;

  // Condition that holds the sequencer on its current step.
  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_INPUT,
    WAIT_OUTPUT
  } wait_e;

  // Condition for taking the jump target instead of the next step.
  typedef enum logic [1:0] {
    JUMP_NEVER,
    JUMP_ALWAYS,
    JUMP_NO_SAMPLE
  } jump_e;

  typedef struct packed {
    op_e   op;
    wait_e wait_on;
    jump_e jump;
    step_t target;
  } ctrl_word_t;

  // Step numbers referred to by name in the program and the checks.
  localparam step_t StepLoad   = 4'd0;
  localparam step_t StepDiff   = 4'd1;
  localparam step_t StepInf    = 4'd5;
  localparam step_t StepDecide = 4'd9;

  // Microprogram: one control word per step.
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t cw;
    case (step)
      4'd0:    cw = '{OP_LOAD,      WAIT_INPUT,  JUMP_NEVER,     StepLoad};
      4'd1:    cw = '{OP_DIFF,      WAIT_NONE,   JUMP_NEVER,     StepLoad};
      4'd2:    cw = '{OP_SPAN,      WAIT_NONE,   JUMP_NO_SAMPLE, StepInf};
      4'd3:    cw = '{OP_BOUNDS,    WAIT_NONE,   JUMP_NEVER,     StepLoad};
      4'd4:    cw = '{OP_SMOOTH,    WAIT_NONE,   JUMP_NEVER,     StepLoad};
      4'd5:    cw = '{OP_INF_RANGE, WAIT_NONE,   JUMP_NEVER,     StepLoad};
      4'd6:    cw = '{OP_MUL_PCT,   WAIT_NONE,   JUMP_NEVER,     StepLoad};
      4'd7:    cw = '{OP_MUL_RECIP, WAIT_NONE,   JUMP_NEVER,     StepLoad};
      4'd8:    cw = '{OP_LIMIT,     WAIT_NONE,   JUMP_NEVER,     StepLoad};
      4'd9:    cw = '{OP_DECIDE,    WAIT_OUTPUT, JUMP_ALWAYS,    StepLoad};
      default: cw = '{OP_NOP,       WAIT_NONE,   JUMP_ALWAYS,    StepLoad};
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/low_priority_congestion_window.sv =====
// Low-priority congestion window controller.
//
// Each transfer on the s_axis channel carries one acknowledgement: the
// two echoed timestamps, the current time and the current window, with
// the sample-valid flag in tuser. Each accepted acknowledgement yields
// exactly one transfer on the m_axis channel with the new window, the
// inference and threshold flags, and the kind of cut in tuser.
// Segment size and threshold percent are written through the cfg port,
// which is always ready; write them only while the block is idle.
//
// A microcoded sequencer steps a small datapath with one shared 32x32
// multiplier through the update: load, difference, span, bounds,
// smoothing, inference and range, two passes through the multiplier,
// limit and decide. Bounds and smoothing are skipped when the delay sample
// is not used. A new acknowledgement is taken only after the decide step
// of the last one. The result sits in an output register; if the receiver
// stalls, the sequencer holds on its last step until that register frees.
// Reset clears the delay history and restores the register defaults.
module low_priority_congestion_window (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input acknowledgements.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] ts_value, [63:32] ts_echo, [95:64] now_time, [127:96] window_in
  input  logic [127:0] s_axis_tdata_i,
  // [0] rtt_valid
  input  logic [0:0]   s_axis_tuser_i,
  // Results.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] window_out, [32] within_inference, [33] within_threshold, rest zero
  output logic [39:0]  m_axis_tdata_o,
  // [1:0] cut_kind
  output logic [1:0]   m_axis_tuser_o,
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  lpcw_pkg::step_t      step_q, step_d;
  lpcw_pkg::ctrl_word_t cw;
  logic                 stall, exec, jump_taken, sample_ok, out_free;

  // Configuration registers.
  logic [15:0] seg_q;
  logic [6:0]  thr_q;

  // Delay history.
  logic [31:0] dmin_q, dmax_q, dres_q, sm_q, last_drop_q;
  logic [33:0] span_q;

  // Captured item and working registers.
  logic        valid_q;
  logic [31:0] tsv_q, tse_q, now_q, win_q;
  logic [31:0] d_q, el_q, acc_q;
  logic        gt_q, inf_q;
  logic [63:0] prod_q;

  // Output register.
  logic                  out_valid_q;
  logic [31:0]           out_win_q;
  logic                  out_inf_q, out_thr_q;
  lpcw_pkg::cut_kind_e   out_kind_q;

  // Shared multiplier and decision logic.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] sm_div8, sm_div4, half_win, floor_win;
  logic [63:0] elapsed;
  logic        in_thr;

  // Sequencer: fetch, hold and branch.
  always_comb begin
    cw         = lpcw_pkg::ucode_rom(step_q);
    out_free   = !out_valid_q || m_axis_tready_i;
    sample_ok  = valid_q && (d_q != 32'd0);
    stall      = ((cw.wait_on == lpcw_pkg::WAIT_INPUT) && !s_axis_tvalid_i) ||
                 ((cw.wait_on == lpcw_pkg::WAIT_OUTPUT) && !out_free);
    exec       = !stall;
    jump_taken = (cw.jump == lpcw_pkg::JUMP_ALWAYS) ||
                 ((cw.jump == lpcw_pkg::JUMP_NO_SAMPLE) && !sample_ok);
    if (stall) begin
      step_d = step_q;
    end else if (jump_taken) begin
      step_d = cw.target;
    end else begin
      step_d = step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= lpcw_pkg::StepLoad;
    end else begin
      step_q <= step_d;
    end
  end

  assign s_axis_tready_o = (cw.wait_on == lpcw_pkg::WAIT_INPUT);
  assign cfg_ready_o     = 1'b1;

  // Multiplier operands: percentage times range, then reciprocal of 100.
  always_comb begin
    if (cw.op == lpcw_pkg::OP_MUL_RECIP) begin
      mul_a = prod_q[31:0];
      mul_b = lpcw_pkg::Recip100;
    end else begin
      mul_a = {25'd0, thr_q};
      mul_b = acc_q;
    end
    mul_p = mul_a * mul_b;
  end

  // Decision terms.
  always_comb begin
    sm_div8   = sm_q >> 3;
    sm_div4   = sm_q >> 2;
    half_win  = win_q >> 1;
    floor_win = (half_win > {16'd0, seg_q}) ? half_win : {16'd0, seg_q};
    in_thr    = (sm_div8 <= acc_q);
    elapsed   = ({32'd0, now_q} - {32'd0, last_drop_q}) & lpcw_pkg::TimeMask;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= lpcw_pkg::SegmentSizeReset;
      thr_q <= lpcw_pkg::ThresholdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lpcw_pkg::REG_SEGMENT_SIZE: seg_q <= cfg_data_i;
        lpcw_pkg::REG_THRESHOLD:    thr_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Delay history, updated by the sample steps and by a cut.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmin_q      <= '1;
      dmax_q      <= '0;
      dres_q      <= '0;
      sm_q        <= '0;
      last_drop_q <= '0;
      span_q      <= '0;
    end else if (exec) begin
      case (cw.op)
        lpcw_pkg::OP_SPAN: begin
          if (gt_q) begin
            span_q <= {2'd0, el_q} + {1'b0, el_q, 1'b0};
          end
        end
        lpcw_pkg::OP_BOUNDS: begin
          if (d_q < dmin_q) begin
            dmin_q <= d_q;
          end
          if (d_q > dmax_q) begin
            if (d_q > dres_q) begin
              dmax_q <= (dres_q == 32'd0) ? d_q : dres_q;
              dres_q <= d_q;
            end else begin
              dmax_q <= d_q;
            end
          end
        end
        lpcw_pkg::OP_SMOOTH: begin
          if (sm_q != 32'd0) begin
            sm_q <= sm_q + d_q - sm_div8;
          end else begin
            sm_q <= d_q << 3;
          end
        end
        lpcw_pkg::OP_DECIDE: begin
          if (!in_thr) begin
            dmin_q      <= sm_div8;
            dmax_q      <= sm_div4;
            dres_q      <= sm_div4;
            last_drop_q <= now_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Captured item and working registers.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      case (cw.op)
        lpcw_pkg::OP_LOAD: begin
          valid_q <= s_axis_tuser_i[0];
          tsv_q   <= s_axis_tdata_i[31:0];
          tse_q   <= s_axis_tdata_i[63:32];
          now_q   <= s_axis_tdata_i[95:64];
          win_q   <= s_axis_tdata_i[127:96];
        end
        lpcw_pkg::OP_DIFF: begin
          d_q  <= (tsv_q >= tse_q) ? (tsv_q - tse_q) : (tse_q - tsv_q);
          el_q <= now_q - tse_q;
          gt_q <= (now_q > tse_q);
        end
        lpcw_pkg::OP_INF_RANGE: begin
          inf_q <= (last_drop_q != 32'd0) && (elapsed < {30'd0, span_q});
          acc_q <= dmax_q - dmin_q;
        end
        lpcw_pkg::OP_MUL_PCT, lpcw_pkg::OP_MUL_RECIP: begin
          prod_q <= mul_p;
        end
        lpcw_pkg::OP_LIMIT: begin
          acc_q <= dmin_q + {5'd0, prod_q[63:lpcw_pkg::Recip100Shift]};
        end
        default: ;
      endcase
    end
  end

  // Output register: loaded by the decide step, freed by a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && (cw.op == lpcw_pkg::OP_DECIDE)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && (cw.op == lpcw_pkg::OP_DECIDE)) begin
      out_inf_q <= inf_q;
      out_thr_q <= in_thr;
      if (in_thr) begin
        out_win_q  <= win_q;
        out_kind_q <= lpcw_pkg::CUT_NONE;
      end else if (inf_q) begin
        out_win_q  <= {16'd0, seg_q};
        out_kind_q <= lpcw_pkg::CUT_SEGMENT;
      end else begin
        out_win_q  <= floor_win;
        out_kind_q <= lpcw_pkg::CUT_HALVED;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_thr_q, out_inf_q, out_win_q};
  assign m_axis_tuser_o  = out_kind_q;

  // A new result appears only after the decide step ran.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(step_q) == lpcw_pkg::StepDecide)
    else $error("result raised outside the decide step");

  // An accepted item starts the program at the difference step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> step_q == lpcw_pkg::StepDiff)
    else $error("sequencer did not advance after input transfer");

  // A result within threshold never reports a cut.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[33]) |->
      m_axis_tuser_o == lpcw_pkg::CUT_NONE)
    else $error("cut reported within threshold");

  // A result above threshold always reports a cut.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[33]) |->
      (m_axis_tuser_o == lpcw_pkg::CUT_HALVED ||
       m_axis_tuser_o == lpcw_pkg::CUT_SEGMENT))
    else $error("no cut reported above threshold");

  // The sequencer never runs past the end of the program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= lpcw_pkg::StepDecide)
    else $error("step counter outside the program");

endmodule
